// ----- src/u2u8_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // register map
    localparam int          ADDR_W         = 3;
    localparam int          DATA_W         = 32;
    localparam logic        REG_BYTE_ORDER = 1'b0;
    localparam logic        REG_DEST_CAP   = 1'b1;
    localparam logic        BYTE_ORDER_RST = 1'b0;
    localparam logic [10:0] DEST_CAP_RST   = 11'd64;

    // default for the top-level parameter
    localparam int MAX_CAPACITY_DEF = 1024;

    // width of a capacity value and of a length that can reach it
    localparam int CAP_W = 11;
    // count plus up to three bytes
    localparam int SUM_W = 12;
    localparam int LEN_W = 10;

    localparam int QUEUE_DEPTH = 2;

    // utf-8 encoding constants
    localparam logic [15:0] LIM_ONE   = 16'h0080;
    localparam logic [15:0] LIM_TWO   = 16'h0800;
    localparam logic [7:0]  LEAD_TWO  = 8'hC0;
    localparam logic [7:0]  LEAD_THR  = 8'hE0;
    localparam logic [7:0]  CONT_BYTE = 8'h80;
    localparam logic [5:0]  CONT_MASK = 6'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_terminator;
        logic [LEN_W-1:0] out_length;
    } out_item_t;

    // one unit's worth of work handed from front to back
    typedef struct packed {
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
        logic [1:0]       nbytes;
        logic             term;
        logic [CAP_W-1:0] base;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- src/u2u8_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_front
// Pairs source bytes into units, sizes the utf-8 encoding, checks capacity
// and queues one job per unit that produces output or ends the string.
// ----------------------------------------------------------------------------
module u2u8_front #(
    parameter int MAX_CAPACITY = u2u8_pkg::MAX_CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           src_valid,
    output logic                           src_stall,
    input  u2u8_pkg::in_item_t             src_data,
    input  logic                           byte_order,
    input  logic [u2u8_pkg::CAP_W-1:0]     dest_capacity,
    input  u2u8_pkg::queue_status_t        q_status,
    output logic                           push,
    output u2u8_pkg::job_t                 job
);

    localparam int CAP_EFF = (MAX_CAPACITY < 2048) ? MAX_CAPACITY : 2048;
    localparam int CNT_W   = $clog2(CAP_EFF);

    logic [7:0]       held_reg, held_next;
    logic             have_half_reg, have_half_next;
    logic             stopped_reg, stopped_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                          accept;
    logic [15:0]                   unit;
    logic [1:0]                    nbytes;
    logic [u2u8_pkg::SUM_W-1:0]    sum;
    logic [u2u8_pkg::SUM_W-1:0]    cap;
    logic                          pairing;
    logic                          emit_unit;

    assign src_stall = q_status.full;
    assign accept    = src_valid && !q_status.full;

    always_comb
    begin
        unit = byte_order ? {held_reg, src_data.in_byte} : {src_data.in_byte, held_reg};

        if (unit < u2u8_pkg::LIM_ONE)
        begin
            nbytes = 2'd1;
        end
        else if (unit < u2u8_pkg::LIM_TWO)
        begin
            nbytes = 2'd2;
        end
        else
        begin
            nbytes = 2'd3;
        end

        // capacity above the maximum is clamped
        if (u2u8_pkg::SUM_W'(dest_capacity) > u2u8_pkg::SUM_W'(CAP_EFF))
        begin
            cap = u2u8_pkg::SUM_W'(CAP_EFF);
        end
        else
        begin
            cap = u2u8_pkg::SUM_W'(dest_capacity);
        end

        sum       = u2u8_pkg::SUM_W'(count_reg) + u2u8_pkg::SUM_W'(nbytes);
        pairing   = !stopped_reg && have_half_reg;
        emit_unit = pairing && (unit != 16'd0) && (sum < cap);

        job.term   = src_data.last_byte;
        job.nbytes = emit_unit ? nbytes : 2'd0;
        job.base   = u2u8_pkg::CAP_W'(count_reg);
        case (nbytes)
            2'd1:
            begin
                job.byte0 = unit[7:0];
                job.byte1 = u2u8_pkg::CONT_BYTE | {2'b00, unit[5:0] & u2u8_pkg::CONT_MASK};
            end
            2'd2:
            begin
                job.byte0 = u2u8_pkg::LEAD_TWO | {3'b000, unit[10:6]};
                job.byte1 = u2u8_pkg::CONT_BYTE | {2'b00, unit[5:0] & u2u8_pkg::CONT_MASK};
            end
            default:
            begin
                job.byte0 = u2u8_pkg::LEAD_THR | {4'b0000, unit[15:12]};
                job.byte1 = u2u8_pkg::CONT_BYTE | {2'b00, unit[11:6] & u2u8_pkg::CONT_MASK};
            end
        endcase
        job.byte2 = u2u8_pkg::CONT_BYTE | {2'b00, unit[5:0] & u2u8_pkg::CONT_MASK};

        push = accept && (emit_unit || src_data.last_byte);

        held_next      = held_reg;
        have_half_next = have_half_reg;
        stopped_next   = stopped_reg;
        count_next     = count_reg;
        if (accept)
        begin
            if (!stopped_reg)
            begin
                if (have_half_reg)
                begin
                    have_half_next = 1'b0;
                    held_next      = 8'd0;
                    if (emit_unit)
                    begin
                        count_next = CNT_W'(sum);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                else
                begin
                    held_next      = src_data.in_byte;
                    have_half_next = 1'b1;
                end
            end
            if (src_data.last_byte)
            begin
                held_next      = 8'd0;
                have_half_next = 1'b0;
                stopped_next   = 1'b0;
                count_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 8'd0;
            have_half_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            held_reg      <= held_next;
            have_half_reg <= have_half_next;
            stopped_reg   <= stopped_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ----- src/u2u8_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module u2u8_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  u2u8_pkg::job_t          push_job,
    input  logic                    pop,
    output u2u8_pkg::job_t          head_job,
    output u2u8_pkg::queue_status_t status
);

    localparam int DEPTH = u2u8_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u8_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- src/u2u8_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_back
// Serializes queued jobs into output beats: the unit's bytes, then the
// terminator when the job ends the string.
// ----------------------------------------------------------------------------
module u2u8_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  u2u8_pkg::job_t          head_job,
    input  u2u8_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    dst_valid,
    input  logic                    dst_stall,
    output u2u8_pkg::out_item_t     dst_data
);

    logic [1:0]                 idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    u2u8_pkg::out_item_t        data_reg, data_next;

    logic                       load;
    logic                       is_byte;
    logic                       last_beat;
    logic [u2u8_pkg::CAP_W-1:0] len;
    logic [7:0]                 sel_byte;

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

    always_comb
    begin
        is_byte = (idx_reg < head_job.nbytes);
        // byte beats carry the count including themselves
        len = head_job.base + u2u8_pkg::CAP_W'(idx_reg) + u2u8_pkg::CAP_W'(is_byte);

        case (idx_reg)
            2'd0:    sel_byte = head_job.byte0;
            2'd1:    sel_byte = head_job.byte1;
            default: sel_byte = head_job.byte2;
        endcase

        if (is_byte)
        begin
            last_beat = (idx_reg == head_job.nbytes - 2'd1) && !head_job.term;
        end
        else
        begin
            last_beat = 1'b1;
        end

        load = !q_status.empty && (!valid_reg || !dst_stall);
        pop  = load && last_beat;

        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next              = 1'b1;
            data_next.out_byte      = is_byte ? sel_byte : 8'd0;
            data_next.is_terminator = !is_byte;
            data_next.out_length    = len[u2u8_pkg::LEN_W-1:0];
            idx_next                = last_beat ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!dst_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- src/utf16_to_utf8_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 byte stream to UTF-8 byte stream converter with length tracking.
// ----------------------------------------------------------------------------
// A source byte is accepted whenever the two-entry job queue has room;
// pairing, encoding size and the capacity check are done at the accept
// edge; a full queue stalls the source. Results leave the output register
// at one beat per cycle while the sink does not stall: a unit yields one
// to three beats and the final byte adds a terminator beat, so the sustained
// rate is set by the output serializer, at worst three beats per byte pair
// plus one beat per string. Each job is written into the queue and then
// loaded into the output register. Registers are at byte address 0 (byte
// order) and 4 (destination capacity) and should be written only while idle.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
    parameter int MAX_CAPACITY = u2u8_pkg::MAX_CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  u2u8_pkg::in_item_t            src_data,
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output u2u8_pkg::out_item_t           dst_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u2u8_pkg::ADDR_W-1:0]   paddr,
    input  logic [u2u8_pkg::DATA_W-1:0]   pwdata,
    output logic [u2u8_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                         byte_order_reg, byte_order_next;
    logic [u2u8_pkg::CAP_W-1:0]   dest_cap_reg, dest_cap_next;
    logic                         wr_en;
    logic                         reg_sel;

    logic                         push;
    logic                         pop;
    u2u8_pkg::job_t               push_job;
    u2u8_pkg::job_t               head_job;
    u2u8_pkg::queue_status_t      q_status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        byte_order_next = byte_order_reg;
        dest_cap_next   = dest_cap_reg;
        if (wr_en)
        begin
            case (reg_sel)
                u2u8_pkg::REG_BYTE_ORDER: byte_order_next = pwdata[0];
                u2u8_pkg::REG_DEST_CAP:   dest_cap_next   = pwdata[u2u8_pkg::CAP_W-1:0];
                default:                  byte_order_next = byte_order_reg;
            endcase
        end

        case (reg_sel)
            u2u8_pkg::REG_BYTE_ORDER: prdata = u2u8_pkg::DATA_W'(byte_order_reg);
            u2u8_pkg::REG_DEST_CAP:   prdata = u2u8_pkg::DATA_W'(dest_cap_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg <= u2u8_pkg::BYTE_ORDER_RST;
            dest_cap_reg   <= u2u8_pkg::DEST_CAP_RST;
        end
        else
        begin
            byte_order_reg <= byte_order_next;
            dest_cap_reg   <= dest_cap_next;
        end
    end

    u2u8_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_data      (src_data),
        .byte_order    (byte_order_reg),
        .dest_capacity (dest_cap_reg),
        .q_status      (q_status),
        .push          (push),
        .job           (push_job)
    );

    u2u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    u2u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

// ----- test/utf16_to_utf8_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_checker
// Watches the source, sink and register ports of the encoder, predicts the
// UTF-8 beats caused by every accepted source byte and compares each sink
// beat, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module utf16_to_utf8_checker
    import u2u8_pkg::*;
#(
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic              src_stall,
    input  in_item_t          src_data,
    input  logic              dst_valid,
    input  logic              dst_stall,
    input  out_item_t         dst_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                errors,
    output int                pending,
    output int                bytes_in,
    output int                beats_out,
    output int                strings_done
);

    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD_OF_TWO    = 8'hC0;
    localparam logic [7:0]  LEAD_OF_THREE  = 8'hE0;
    localparam logic [7:0]  CONTINUATION   = 8'h80;
    localparam int          REPORT_LIMIT   = 10;

    // shadow of the registers and of the conversion state
    logic             big_endian;
    logic [CAP_W-1:0] capacity;
    logic [7:0]       held;
    logic             half;
    logic [LEN_W-1:0] count;
    logic             halted;

    out_item_t utf8_q[$];
    int        mismatch_cnt;
    int        byte_cnt;
    int        beat_cnt;
    int        string_cnt;

    task automatic note_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
            $display("[%0t] %s: expected byte %02h term %0b len %0d, got byte %02h term %0b len %0d",
                     $realtime, what, want.out_byte, want.is_terminator, want.out_length,
                     got.out_byte, got.is_terminator, got.out_length);
    endtask

    task automatic push_utf8(input logic [7:0] b);
        count = count + 1'b1;
        utf8_q.push_back('{out_byte: b, is_terminator: 1'b0, out_length: count});
    endtask

    task automatic encode_unit(input logic [15:0] cu);
        int         lim;
        int         n;
        logic [7:0] seq [3];
        lim = (int'(capacity) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity);
        if (cu < ONE_BYTE_LIMIT)
        begin
            n = 1;
            seq[0] = cu[7:0];
        end
        else if (cu < TWO_BYTE_LIMIT)
        begin
            n = 2;
            seq[0] = LEAD_OF_TWO | {3'b000, cu[10:6]};
            seq[1] = CONTINUATION | {2'b00, cu[5:0]};
        end
        else
        begin
            n = 3;
            seq[0] = LEAD_OF_THREE | {4'b0000, cu[15:12]};
            seq[1] = CONTINUATION | {2'b00, cu[11:6]};
            seq[2] = CONTINUATION | {2'b00, cu[5:0]};
        end
        // a zero unit ends the string, as does an encoding that leaves no room for the nul
        if (cu == 16'h0000 || int'(count) + n >= lim)
            halted = 1'b1;
        else
            for (int i = 0; i < n; i++)
                push_utf8(seq[i]);
    endtask

    task automatic predict_byte(input in_item_t it);
        if (!halted)
        begin
            if (half)
            begin
                half = 1'b0;
                encode_unit(big_endian ? {held, it.in_byte} : {it.in_byte, held});
                held = 8'h00;
            end
            else
            begin
                held = it.in_byte;
                half = 1'b1;
            end
        end
        // a held odd byte is simply dropped here
        if (it.last_byte)
        begin
            utf8_q.push_back('{out_byte: 8'h00, is_terminator: 1'b1, out_length: count});
            held   = 8'h00;
            half   = 1'b0;
            count  = '0;
            halted = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            big_endian = 1'b0;
            capacity   = 11'd64;
            held       = 8'h00;
            half       = 1'b0;
            count      = '0;
            halted     = 1'b0;
            utf8_q.delete();
            mismatch_cnt = 0;
            byte_cnt     = 0;
            beat_cnt     = 0;
            string_cnt   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1:2] == REG_BYTE_ORDER)
                    big_endian = pwdata[0];
                else if (paddr[ADDR_W-1:2] == REG_DEST_CAP)
                    capacity = pwdata[CAP_W-1:0];
            end
            if (dst_valid && !dst_stall)
            begin
                beat_cnt++;
                if (dst_data.is_terminator)
                    string_cnt++;
                if (utf8_q.size() == 0)
                    note_mismatch("beat with nothing outstanding", '0, dst_data);
                else
                begin
                    want = utf8_q.pop_front();
                    if (dst_data.out_byte !== want.out_byte
                        || dst_data.is_terminator !== want.is_terminator
                        || dst_data.out_length !== want.out_length)
                        note_mismatch("beat mismatch", want, dst_data);
                end
            end
            if (src_valid && !src_stall)
            begin
                byte_cnt++;
                predict_byte(src_data);
            end
        end
        errors       <= mismatch_cnt;
        pending      <= utf8_q.size();
        bytes_in     <= byte_cnt;
        beats_out    <= beat_cnt;
        strings_done <= string_cnt;
    end

endmodule

// ----- test/tb_utf16_to_utf8_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder
// Drives UTF-16 byte strings into the encoder under both byte orders and several
// destination capacities, with random pacing on both channels; the checker
// beside the block predicts and compares every UTF-8 beat.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder;
    import u2u8_pkg::*;

    localparam int LIMIT     = 200000;
    localparam int LONG_HOLD = 60;
    localparam int SETTLE    = 8;

    logic              clk;
    logic              rst_n;
    logic              src_valid;
    logic              src_stall;
    in_item_t          src_data;
    logic              dst_valid;
    logic              dst_stall;
    out_item_t         dst_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic pace_on;
    logic hold_tog;
    logic be_now;
    int   errors;
    int   pending;
    int   bytes_in;
    int   beats_out;
    int   strings_done;
    int   cycles;
    int   settings_run;

    utf16_to_utf8_encoder dut (.*);

    utf16_to_utf8_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .src_data     (src_data),
        .dst_valid    (dst_valid),
        .dst_stall    (dst_stall),
        .dst_data     (dst_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .pending      (pending),
        .bytes_in     (bytes_in),
        .beats_out    (beats_out),
        .strings_done (strings_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sink pacing, plus one long hold-off whenever hold_tog flips
    initial
    begin : sink_pacing
        int   left;
        int   r;
        logic hold_seen;
        left      = 0;
        hold_seen = 1'b0;
        dst_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                if (hold_tog != hold_seen)
                begin
                    hold_seen = hold_tog;
                    left      = LONG_HOLD;
                end
                else if (pace_on && rst_n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        left = 0;
                    else if (r < 93)
                        left = $urandom_range(1, 3);
                    else
                        left = $urandom_range(8, 30);
                end
            end
            if (left > 0)
            begin
                dst_stall <= 1'b1;
                left--;
            end
            else
                dst_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped after %0d cycles without finishing", cycles);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!pace_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 20);
    endfunction

    task automatic apb_write(input logic reg_sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        src_valid <= 1'b1;
        src_data  <= '{in_byte: b, last_byte: lst};
        do @(posedge clk); while (src_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            push_byte(q[i], i == q.size() - 1);
    endtask

    // hold the source off until every predicted beat has come out
    task automatic drain();
        src_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_string(output int sent);
        logic [7:0]  q[$];
        logic [15:0] cu;
        int          kind;
        if ($urandom_range(0, 9) < 8)
        begin
            repeat ($urandom_range(1, 8))
            begin
                kind = $urandom_range(0, 19);
                if (kind < 6)
                    cu = 16'($urandom_range(1, 16'h007F));
                else if (kind < 11)
                    cu = 16'($urandom_range(16'h0080, 16'h07FF));
                else if (kind < 16)
                    cu = 16'($urandom_range(16'h0800, 16'hFFFF));
                else if (kind < 19)
                    cu = 16'($urandom_range(16'hD800, 16'hDFFF));
                else
                    cu = 16'h0000;
                if (be_now)
                begin
                    q.push_back(cu[15:8]);
                    q.push_back(cu[7:0]);
                end
                else
                begin
                    q.push_back(cu[7:0]);
                    q.push_back(cu[15:8]);
                end
            end
            // odd trailing byte now and then
            if ($urandom_range(0, 4) == 0)
                q.push_back(8'($urandom_range(0, 255)));
        end
        else
            repeat ($urandom_range(1, 9))
                q.push_back(8'($urandom_range(0, 255)));
        send_bytes(q);
        sent = q.size();
    endtask

    task automatic run_phase(input logic order, input logic [CAP_W-1:0] cap, input int budget,
                             input logic paced, input logic long_hold, input logic mid_pause);
        int used;
        int got;
        apb_write(REG_BYTE_ORDER, DATA_W'(order));
        apb_write(REG_DEST_CAP, DATA_W'(cap));
        be_now  = order;
        pace_on <= paced;
        if (long_hold)
            hold_tog <= ~hold_tog;
        used = 0;
        while (used < budget)
        begin
            send_string(got);
            used += got;
            if (mid_pause && used >= budget / 2)
            begin
                drain();
                mid_pause = 1'b0;
            end
        end
        drain();
        repeat (SETTLE) @(posedge clk);
        settings_run++;
    endtask

    initial
    begin : stimulus
        logic [7:0] q[$];
        rst_n        = 1'b0;
        src_valid    = 1'b0;
        src_data     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pace_on      = 1'b1;
        hold_tog     = 1'b0;
        be_now       = 1'b0;
        settings_run = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: little-endian, capacity 64
        // range edges of each encoding length, a surrogate, 0xffff, odd trailing byte
        q = {8'h41, 8'h00, 8'h7F, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h07,
             8'h00, 8'h08, 8'h3D, 8'hD8, 8'hFF, 8'hFF, 8'h55};
        send_bytes(q);
        // last byte completes a three-byte unit: four beats from one byte
        q = {8'hAC, 8'h20};
        send_bytes(q);
        // zero unit stops conversion, the rest is ignored
        q = {8'h42, 8'h00, 8'h00, 8'h00, 8'h43, 8'h00};
        send_bytes(q);
        // a lone last byte gives only the terminator
        q = {8'h9A};
        send_bytes(q);
        drain();
        repeat (SETTLE) @(posedge clk);

        run_phase(1'b1, 11'd1, 4, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 11'd0, 4, 1'b1, 1'b0, 1'b0);
        run_phase(1'b1, 11'd2047, 20, 1'b1, 1'b1, 1'b0);
        run_phase(1'b0, CAP_W'($urandom_range(2, 24)), 8, 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 11'd1024, 10, 1'b1, 1'b0, 1'b1);
        run_phase(1'b0, CAP_W'($urandom_range(4, 40)), 8, 1'b1, 1'b0, 1'b0);

        $display("covered %0d source bytes in %0d strings, %0d result beats checked",
                 bytes_in, strings_done, beats_out);
        $display("%0d register settings beyond reset: both byte orders, capacities 0, 1, 1024, 2047",
                 settings_run);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
